/* rtl/tws_pkg.sv */
// Shared types and constants for the three-wire serial byte master.
// No dependencies; used by the interfaces, the step logic and the top level.
package tws_pkg;

    localparam int BITS_PER_BYTE = 8;

    // Transaction phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LOW   = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_WDATA = 3'd3;
    localparam logic [2:0] PH_RDATA = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    // Command byte markers
    localparam logic [7:0] CMD_READ  = 8'h81;
    localparam logic [7:0] CMD_WRITE = 8'h80;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;

    typedef struct packed {
        logic       start_req;
        logic       opcode;
        logic [5:0] reg_address;
        logic [7:0] write_data;
        logic       data_in;
    } t_in_item;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_out;
        logic [7:0] shift_in;
        logic [7:0] divider_count;
        logic       clock_level;
        logic       is_write;
        logic [7:0] pending_data;
    } t_state;

endpackage

/* rtl/tws_in_if.sv */
// Input channel of the serial master: one tick beat per transfer.
// Depends on tws_pkg for the payload type.
interface tws_in_if;
    logic              valid;
    logic              ready;
    tws_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tws_out_if.sv */
// Result channel of the serial master: pin levels and status per beat.
// Depends on tws_pkg for the payload type.
interface tws_out_if;
    logic               valid;
    logic               ready;
    tws_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/three_wire_serial_byte_master_top.sv */
// Three-wire serial byte master: chip enable, serial clock and data pin driver.
// Depends on tws_pkg, tws_in_if, tws_out_if and tws_step.
//
// Each input beat is one tick. A start request while idle begins a transaction:
// the lines are held low for one clock half period, then chip enable rises and a
// command byte (address and read/write flag) goes out LSB first, followed by the
// write byte or eight sampled read bits. Each tick yields one result beat with the
// pin levels, busy, a one-tick done flag and the last read byte. The block takes
// one beat per cycle; the tick's state update is a single pass of tws_step between
// the state register and the result register, and a new beat is accepted whenever
// the result register is empty or being drained in the same cycle. Half period
// length in ticks is set by the configuration register (0 acts as 1, reset 4).
module three_wire_serial_byte_master_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tws_in_if.sink     i_in,
    tws_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    tws_pkg::t_state    r_state;
    tws_pkg::t_state    n_state;
    tws_pkg::t_out_item r_res;
    tws_pkg::t_out_item n_res;
    logic               r_res_valid;
    logic [7:0]         r_half_period;
    logic               accept;

    tws_step u_step (
        .i_state       (r_state),
        .i_item        (i_in.data),
        .i_half_period (r_half_period),
        .o_state       (n_state),
        .o_res         (n_res)
    );

    assign i_in.ready  = !r_res_valid || o_res.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= tws_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.busy_res && r_res.done_res))
        else $error("busy and done both set in one result");

    a_done_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == tws_pkg::PH_DONE) && !$stable(r_state.phase) |->
            ($past(r_state.phase) == tws_pkg::PH_WDATA)
            || ($past(r_state.phase) == tws_pkg::PH_RDATA))
        else $error("done reached without a data byte");

    a_ce_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.chip_enable |-> r_res.busy_res)
        else $error("chip enable outside a transaction");

    a_read_byte_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_state.shift_in) |-> (r_state.phase == tws_pkg::PH_DONE))
        else $error("read byte changed outside the end of a read");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

endmodule

/* rtl/tws_step.sv */
// Next-state and pin logic for one tick of the serial master.
// Purely combinational; depends on tws_pkg.
module tws_step (
    input  tws_pkg::t_state    i_state,
    input  tws_pkg::t_in_item  i_item,
    input  logic [7:0]         i_half_period,
    output tws_pkg::t_state    o_state,
    output tws_pkg::t_out_item o_res
);

    tws_pkg::t_state n;
    logic [7:0]      limit;
    logic            active;

    always_comb begin
        n     = i_state;
        limit = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
        if ((i_state.phase < tws_pkg::PH_LOW) || (i_state.phase > tws_pkg::PH_RDATA)) begin
            if (i_item.start_req) begin
                n.is_write      = i_item.opcode;
                n.shift_out     = {1'b0, i_item.reg_address, 1'b0}
                                  | (i_item.opcode ? tws_pkg::CMD_WRITE : tws_pkg::CMD_READ);
                n.pending_data  = i_item.write_data;
                n.phase         = tws_pkg::PH_LOW;
                n.divider_count = 8'd0;
                n.clock_level   = 1'b0;
                n.bit_count     = 4'd0;
            end else begin
                n.phase = tws_pkg::PH_IDLE;
            end
        end else if (({1'b0, i_state.divider_count} + 9'd1) >= {1'b0, limit}) begin
            n.divider_count = 8'd0;
            if (i_state.phase == tws_pkg::PH_LOW) begin
                n.phase       = tws_pkg::PH_CMD;
                n.bit_count   = 4'd0;
                n.clock_level = 1'b0;
            end else if (!i_state.clock_level) begin
                // sample just before the rising edge
                if (i_state.phase == tws_pkg::PH_RDATA) begin
                    n.pending_data = {i_item.data_in, i_state.pending_data[7:1]};
                end
                n.clock_level = 1'b1;
            end else begin
                n.clock_level = 1'b0;
                if (i_state.phase != tws_pkg::PH_RDATA) begin
                    n.shift_out = {1'b0, i_state.shift_out[7:1]};
                end
                n.bit_count = i_state.bit_count + 4'd1;
                if (n.bit_count >= 4'(tws_pkg::BITS_PER_BYTE)) begin
                    if (i_state.phase == tws_pkg::PH_CMD) begin
                        n.bit_count = 4'd0;
                        if (i_state.is_write) begin
                            n.shift_out = i_state.pending_data;
                            n.phase     = tws_pkg::PH_WDATA;
                        end else begin
                            n.pending_data = 8'd0;
                            n.phase        = tws_pkg::PH_RDATA;
                        end
                    end else if (i_state.phase == tws_pkg::PH_WDATA) begin
                        n.phase = tws_pkg::PH_DONE;
                    end else begin
                        n.shift_in = i_state.pending_data;
                        n.phase    = tws_pkg::PH_DONE;
                    end
                end
            end
        end else begin
            n.divider_count = i_state.divider_count + 8'd1;
        end
    end

    assign active = (n.phase == tws_pkg::PH_CMD) || (n.phase == tws_pkg::PH_WDATA)
                    || (n.phase == tws_pkg::PH_RDATA);

    always_comb begin
        o_res.chip_enable  = active;
        o_res.serial_clock = active & n.clock_level;
        o_res.data_out     = ((n.phase == tws_pkg::PH_CMD) || (n.phase == tws_pkg::PH_WDATA))
                             & n.shift_out[0];
        o_res.data_drive   = (n.phase == tws_pkg::PH_LOW) || (n.phase == tws_pkg::PH_CMD)
                             || (n.phase == tws_pkg::PH_WDATA);
        o_res.busy_res     = (n.phase >= tws_pkg::PH_LOW) && (n.phase <= tws_pkg::PH_RDATA);
        o_res.done_res     = (n.phase == tws_pkg::PH_DONE);
        o_res.read_data    = n.shift_in;
    end

    assign o_state = n;

endmodule

/* verif/three_wire_serial_byte_master_top_tb.sv */
// Self-checking testbench for the three-wire serial byte master top level.
// Depends on tws_pkg, tws_in_if, tws_out_if and the RTL top; each tick beat is
// predicted in step with the block and every result beat is checked in order.
module three_wire_serial_byte_master_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // data pin level on the ticks of a transaction
    localparam int DIN_LOW    = 0;
    localparam int DIN_HIGH   = 1;
    localparam int DIN_RANDOM = 2;

    localparam int MAX_REPORTS = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    tws_in_if  tick_if ();
    tws_out_if pin_if ();

    three_wire_serial_byte_master_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (tick_if),
        .o_res       (pin_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor state, kept in step with accepted tick beats
    tws_pkg::t_state link_state;
    logic [7:0]      half_period;

    tws_pkg::t_out_item pin_levels_due[$];
    tws_pkg::t_out_item due_levels;
    int                 fail_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        pin_if.ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    // Advances the serial link by one tick and returns the pin levels after it.
    function automatic tws_pkg::t_out_item advance_tick(input tws_pkg::t_in_item it);
        tws_pkg::t_out_item lv;
        logic [7:0]         ticks;
        if (!(link_state.phase >= tws_pkg::PH_LOW && link_state.phase <= tws_pkg::PH_RDATA))
        begin
            if (it.start_req) begin
                link_state.is_write      = it.opcode;
                link_state.shift_out     = {1'b0, it.reg_address, 1'b0} |
                                           (it.opcode ? tws_pkg::CMD_WRITE
                                                      : tws_pkg::CMD_READ);
                link_state.pending_data  = it.write_data;
                link_state.phase         = tws_pkg::PH_LOW;
                link_state.divider_count = 8'd0;
                link_state.clock_level   = 1'b0;
                link_state.bit_count     = 4'd0;
            end else begin
                link_state.phase = tws_pkg::PH_IDLE;
            end
        end else begin
            ticks = (half_period == 8'd0) ? 8'd1 : half_period;
            if ({1'b0, link_state.divider_count} + 9'd1 >= {1'b0, ticks}) begin
                link_state.divider_count = 8'd0;
                if (link_state.phase == tws_pkg::PH_LOW) begin
                    link_state.phase       = tws_pkg::PH_CMD;
                    link_state.bit_count   = 4'd0;
                    link_state.clock_level = 1'b0;
                end else if (!link_state.clock_level) begin
                    // read bits are sampled just before the rising edge
                    if (link_state.phase == tws_pkg::PH_RDATA)
                        link_state.pending_data = {it.data_in,
                                                   link_state.pending_data[7:1]};
                    link_state.clock_level = 1'b1;
                end else begin
                    link_state.clock_level = 1'b0;
                    if (link_state.phase != tws_pkg::PH_RDATA)
                        link_state.shift_out = link_state.shift_out >> 1;
                    link_state.bit_count = link_state.bit_count + 4'd1;
                    if (link_state.bit_count >= tws_pkg::BITS_PER_BYTE) begin
                        if (link_state.phase == tws_pkg::PH_CMD) begin
                            link_state.bit_count = 4'd0;
                            if (link_state.is_write) begin
                                link_state.shift_out = link_state.pending_data;
                                link_state.phase     = tws_pkg::PH_WDATA;
                            end else begin
                                link_state.pending_data = 8'd0;
                                link_state.phase        = tws_pkg::PH_RDATA;
                            end
                        end else if (link_state.phase == tws_pkg::PH_WDATA) begin
                            link_state.phase = tws_pkg::PH_DONE;
                        end else begin
                            link_state.shift_in = link_state.pending_data;
                            link_state.phase    = tws_pkg::PH_DONE;
                        end
                    end
                end
            end else begin
                link_state.divider_count = link_state.divider_count + 8'd1;
            end
        end

        lv.chip_enable  = (link_state.phase == tws_pkg::PH_CMD ||
                           link_state.phase == tws_pkg::PH_WDATA ||
                           link_state.phase == tws_pkg::PH_RDATA);
        lv.serial_clock = lv.chip_enable & link_state.clock_level;
        lv.data_out     = (link_state.phase == tws_pkg::PH_CMD ||
                           link_state.phase == tws_pkg::PH_WDATA) ?
                          link_state.shift_out[0] : 1'b0;
        lv.data_drive   = (link_state.phase == tws_pkg::PH_LOW ||
                           link_state.phase == tws_pkg::PH_CMD ||
                           link_state.phase == tws_pkg::PH_WDATA);
        lv.busy_res     = (link_state.phase >= tws_pkg::PH_LOW &&
                           link_state.phase <= tws_pkg::PH_RDATA);
        lv.done_res     = (link_state.phase == tws_pkg::PH_DONE);
        lv.read_data    = link_state.shift_in;
        return lv;
    endfunction

    always @(posedge clk) begin
        if (rst_n && pin_if.valid && pin_if.ready) begin
            if (pin_levels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: %h", $realtime,
                             pin_if.data);
            end else begin
                due_levels = pin_levels_due.pop_front();
                if (pin_if.data !== due_levels) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch ce/sclk/dout/drv/busy/done/rd exp %b %b %b %b %b %b %h",
                                 $realtime,
                                 due_levels.chip_enable, due_levels.serial_clock,
                                 due_levels.data_out, due_levels.data_drive,
                                 due_levels.busy_res, due_levels.done_res,
                                 due_levels.read_data);
                        $display("%0t: mismatch ce/sclk/dout/drv/busy/done/rd got %b %b %b %b %b %b %h",
                                 $realtime,
                                 pin_if.data.chip_enable, pin_if.data.serial_clock,
                                 pin_if.data.data_out, pin_if.data.data_drive,
                                 pin_if.data.busy_res, pin_if.data.done_res,
                                 pin_if.data.read_data);
                    end
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_tick(input tws_pkg::t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_if.valid = 1'b0;
            @(negedge clk);
        end
        tick_if.valid = 1'b1;
        tick_if.data  = it;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        pin_levels_due.push_back(advance_tick(it));
        @(negedge clk);
    endtask

    task automatic drain_results();
        tick_if.valid = 1'b0;
        while (pin_levels_due.size() != 0) @(negedge clk);
    endtask

    task automatic set_half_period(input logic [7:0] ticks);
        cfg_wdata = ticks;
        cfg_we    = 1'b1;
        @(posedge clk);
        half_period = ticks;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic tws_pkg::t_in_item random_tick(input logic start, input int din_mode);
        tws_pkg::t_in_item it;
        it.start_req   = start;
        it.opcode      = 1'($urandom_range(1));
        it.reg_address = 6'($urandom_range(63));
        it.write_data  = 8'($urandom_range(255));
        case (din_mode)
            DIN_LOW:  it.data_in = 1'b0;
            DIN_HIGH: it.data_in = 1'b1;
            default:  it.data_in = 1'($urandom_range(1));
        endcase
        return it;
    endfunction

    task automatic start_txn(input logic op, input logic [5:0] addr,
                             input logic [7:0] wdata);
        tws_pkg::t_in_item it;
        it = random_tick(1'b1, DIN_RANDOM);
        it.opcode      = op;
        it.reg_address = addr;
        it.write_data  = wdata;
        send_tick(it);
    endtask

    // poke: keep start_req high on busy ticks, which must be ignored
    task automatic finish_txn(input int din_mode, input logic poke);
        while (link_state.phase != tws_pkg::PH_DONE)
            send_tick(random_tick(poke, din_mode));
    endtask

    task automatic run_txn(input logic op, input logic [5:0] addr, input logic [7:0] wdata,
                           input int din_mode);
        start_txn(op, addr, wdata);
        finish_txn(din_mode, 1'b0);
    endtask

    task automatic test_reset_divider();
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        run_txn(OP_READ, 6'd0, 8'h00, DIN_LOW);
        run_txn(OP_WRITE, 6'd63, 8'hff, DIN_RANDOM);
        run_txn(OP_READ, 6'd63, 8'hff, DIN_HIGH);
        run_txn(OP_WRITE, 6'd0, 8'h00, DIN_HIGH);
        drain_results();
    endtask

    task automatic test_divider_extremes();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_half_period(8'd0);
        run_txn(OP_READ, 6'h15, 8'h3c, DIN_RANDOM);
        drain_results();
        // longest half period: run through the low hold and the first serial clock half
        set_half_period(8'd255);
        start_txn(OP_WRITE, 6'h2a, 8'h5a);
        repeat (599) send_tick(random_tick(1'b0, DIN_RANDOM));
        drain_results();
        set_half_period(8'd1);
        finish_txn(DIN_RANDOM, 1'b0);
        run_txn(OP_READ, 6'h3f, 8'h00, DIN_HIGH);
        run_txn(OP_WRITE, 6'h01, 8'ha5, DIN_LOW);
        drain_results();
    endtask

    task automatic test_start_while_busy();
        sender_idle_pct    = 0;
        receiver_stall_pct = 69;
        set_half_period(8'd2);
        start_txn(OP_READ, 6'h2b, 8'h81);
        finish_txn(DIN_RANDOM, 1'b1);
        // back to back: start on the tick right after done
        start_txn(OP_WRITE, 6'h14, 8'h7e);
        finish_txn(DIN_RANDOM, 1'b1);
        drain_results();
    endtask

    // Divider rewritten during a transaction: in the low hold of a write, then mid command byte of a read.
    task automatic test_divider_retune();
        sender_idle_pct    = 69;
        receiver_stall_pct = 0;
        set_half_period(8'd8);
        start_txn(OP_WRITE, 6'h33, 8'hc3);
        repeat (5) send_tick(random_tick(1'b0, DIN_RANDOM));
        drain_results();
        set_half_period(8'd2);
        finish_txn(DIN_RANDOM, 1'b0);
        drain_results();
        set_half_period(8'd3);
        start_txn(OP_READ, 6'h0c, 8'h00);
        repeat (40) send_tick(random_tick(1'b0, DIN_RANDOM));
        drain_results();
        set_half_period(8'd7);
        finish_txn(DIN_RANDOM, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int stage;
        for (stage = 0; stage < 5; stage++) begin
            case (stage)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                3: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            case (stage)
                0: set_half_period(8'd1);
                1: set_half_period(8'd2);
                2: set_half_period(8'd3);
                3: set_half_period(8'($urandom_range(1, 6)));
                default: set_half_period(8'd0);
            endcase
            // mostly start requests, so transactions follow closely
            repeat (80) send_tick(random_tick($urandom_range(3) != 0, DIN_RANDOM));
            drain_results();
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 8'd0;
        tick_if.valid  = 1'b0;
        tick_if.data   = '0;
        pin_if.ready   = 1'b0;
        link_state       = '0;
        link_state.phase = tws_pkg::PH_IDLE;
        half_period      = tws_pkg::HALF_PERIOD_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_divider();
        test_divider_extremes();
        test_start_while_busy();
        test_divider_retune();
        test_random_traffic();

        drain_results();
        repeat (16) @(negedge clk);
        if (fail_count == 0)
            $display("three_wire_serial_byte_master_top verification clean");
        else
            $display("three_wire_serial_byte_master_top verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("three_wire_serial_byte_master_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tws_pkg.sv
rtl/tws_in_if.sv
rtl/tws_out_if.sv
rtl/tws_step.sv
rtl/three_wire_serial_byte_master_top.sv
verif/three_wire_serial_byte_master_top_tb.sv
